[src/rcpi_pkg.sv]
// ----------------------------------------------------------------------------
// rcpi_pkg
// Shared widths, register codes and stage records for the rounded cone
// point inclusion pipeline.
// ----------------------------------------------------------------------------
package rcpi_pkg;

    localparam int CoordW    = 32;   // Q16.16 coordinate
    localparam int OffW      = 33;   // exact coordinate difference
    localparam int SumW      = 34;   // offset plus a depth
    localparam int SqW       = 65;   // square of an offset magnitude
    localparam int RhoW      = 66;   // dx^2 + dz^2
    localparam int DepthW    = 31;
    localparam int RadW      = 63;
    localparam int CotW      = 32;
    localparam int MagW      = 31;   // |dy| and |dy + center| inside the height window
    localparam int SmallSqW  = 62;
    localparam int CapLhsW   = 67;
    localparam int LoW       = 32;   // low slice of rho2 for the split product
    localparam int HiW       = 34;   // high slice of rho2
    localparam int PpLoW     = 64;
    localparam int PpHiW     = 66;
    localparam int ProdW     = 98;
    localparam int LhsW      = 78;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 63;

    localparam logic [DepthW-1:0] ConeHeightRst = 31'd65536;
    localparam logic [CotW-1:0]   CotSqRst      = 32'd65536;

    typedef enum logic [CfgIdxW-1:0] {
        REG_TIP_X        = 3'd0,
        REG_TIP_Y        = 3'd1,
        REG_TIP_Z        = 3'd2,
        REG_CONE_HEIGHT  = 3'd3,
        REG_CAP_FLAT     = 3'd4,
        REG_CAP_CENTER   = 3'd5,
        REG_CAP_RAD_SQ   = 3'd6,
        REG_COT_SQ       = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [CoordW-1:0] tip_x;
        logic signed [CoordW-1:0] tip_y;
        logic signed [CoordW-1:0] tip_z;
        logic [DepthW-1:0]        cone_height;
        logic [DepthW-1:0]        cap_flat_depth;
        logic [DepthW-1:0]        cap_center_depth;
        logic [RadW-1:0]          cap_radius_sq;
        logic [CotW-1:0]          half_angle_cot_sq;
    } cfg_t;

    // geometry handed from the front stages to the test stages
    typedef struct packed {
        logic                valid;
        logic                reject;   // above tip or below base
        logic                body;     // slope test applies
        logic [RhoW-1:0]     rho2;
        logic [SmallSqW-1:0] s2;       // (dy + center)^2
        logic [SmallSqW-1:0] d2;       // dy^2
    } geo_t;

endpackage

[src/rcpi_front.sv]
// ----------------------------------------------------------------------------
// rcpi_front
// Stages 1 to 3: offsets from the tip, height classification, squares and
// the radial distance squared.
// ----------------------------------------------------------------------------
module rcpi_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pipe_en,
    input  logic                              take,
    input  logic signed [rcpi_pkg::CoordW-1:0] point_x,
    input  logic signed [rcpi_pkg::CoordW-1:0] point_y,
    input  logic signed [rcpi_pkg::CoordW-1:0] point_z,
    input  rcpi_pkg::cfg_t                    cfg,
    output rcpi_pkg::geo_t                    geo
);

    // stage 1
    logic                              v1_reg;
    logic signed [rcpi_pkg::OffW-1:0]  dx1_reg, dy1_reg, dz1_reg;
    logic signed [rcpi_pkg::OffW-1:0]  dx1_next, dy1_next, dz1_next;

    // stage 2
    logic                              v2_reg;
    logic [rcpi_pkg::SqW-1:0]          dxsq2_reg, dzsq2_reg;
    logic [rcpi_pkg::SqW-1:0]          dxsq2_next, dzsq2_next;
    logic signed [rcpi_pkg::SumW-1:0]  s2_reg, s2_next;
    logic signed [rcpi_pkg::OffW-1:0]  dy2_reg;
    logic                              rej2_reg, rej2_next;
    logic                              body2_reg, body2_next;

    // stage 3
    logic                              v3_reg;
    logic [rcpi_pkg::RhoW-1:0]         rho3_reg, rho3_next;
    logic [rcpi_pkg::SmallSqW-1:0]     ssq3_reg, ssq3_next;
    logic [rcpi_pkg::SmallSqW-1:0]     dsq3_reg, dsq3_next;
    logic                              rej3_reg, body3_reg;

    logic [rcpi_pkg::OffW-1:0]         absx, absz;
    logic signed [rcpi_pkg::SumW-1:0]  dy_ext, neg_height, neg_flat;
    logic [rcpi_pkg::SumW-1:0]         s_abs_full;
    logic [rcpi_pkg::OffW-1:0]         dy_abs_full;
    logic [rcpi_pkg::MagW-1:0]         s_abs, dy_abs;
    logic [2*rcpi_pkg::OffW-1:0]       sqx_full, sqz_full;

    always_comb
    begin
        dx1_next = {point_x[rcpi_pkg::CoordW-1], point_x}
                 - {cfg.tip_x[rcpi_pkg::CoordW-1], cfg.tip_x};
        dy1_next = {point_y[rcpi_pkg::CoordW-1], point_y}
                 - {cfg.tip_y[rcpi_pkg::CoordW-1], cfg.tip_y};
        dz1_next = {point_z[rcpi_pkg::CoordW-1], point_z}
                 - {cfg.tip_z[rcpi_pkg::CoordW-1], cfg.tip_z};
    end

    always_comb
    begin
        absx = dx1_reg[rcpi_pkg::OffW-1] ? rcpi_pkg::OffW'(-dx1_reg) : dx1_reg;
        absz = dz1_reg[rcpi_pkg::OffW-1] ? rcpi_pkg::OffW'(-dz1_reg) : dz1_reg;
        sqx_full = {{rcpi_pkg::OffW{1'b0}}, absx} * {{rcpi_pkg::OffW{1'b0}}, absx};
        sqz_full = {{rcpi_pkg::OffW{1'b0}}, absz} * {{rcpi_pkg::OffW{1'b0}}, absz};
        dxsq2_next = sqx_full[rcpi_pkg::SqW-1:0];
        dzsq2_next = sqz_full[rcpi_pkg::SqW-1:0];

        dy_ext     = {dy1_reg[rcpi_pkg::OffW-1], dy1_reg};
        neg_height = rcpi_pkg::SumW'(0) - {3'b000, cfg.cone_height};
        neg_flat   = rcpi_pkg::SumW'(0) - {3'b000, cfg.cap_flat_depth};
        s2_next    = dy_ext + {3'b000, cfg.cap_center_depth};

        // above the tip, or below the base plane
        rej2_next  = (!dy1_reg[rcpi_pkg::OffW-1] && (dy1_reg != '0))
                   || (dy_ext < neg_height);
        body2_next = (dy_ext <= neg_flat);
    end

    // magnitudes fit in 31 bits whenever the height window passes
    always_comb
    begin
        s_abs_full  = s2_reg[rcpi_pkg::SumW-1] ? rcpi_pkg::SumW'(-s2_reg) : s2_reg;
        dy_abs_full = dy2_reg[rcpi_pkg::OffW-1] ? rcpi_pkg::OffW'(-dy2_reg) : dy2_reg;
        s_abs       = s_abs_full[rcpi_pkg::MagW-1:0];
        dy_abs      = dy_abs_full[rcpi_pkg::MagW-1:0];
        ssq3_next   = {{rcpi_pkg::MagW{1'b0}}, s_abs} * {{rcpi_pkg::MagW{1'b0}}, s_abs};
        dsq3_next   = {{rcpi_pkg::MagW{1'b0}}, dy_abs} * {{rcpi_pkg::MagW{1'b0}}, dy_abs};
        rho3_next   = {1'b0, dxsq2_reg} + {1'b0, dzsq2_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            v1_reg <= take;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            dx1_reg   <= dx1_next;
            dy1_reg   <= dy1_next;
            dz1_reg   <= dz1_next;
            dxsq2_reg <= dxsq2_next;
            dzsq2_reg <= dzsq2_next;
            s2_reg    <= s2_next;
            dy2_reg   <= dy1_reg;
            rej2_reg  <= rej2_next;
            body2_reg <= body2_next;
            rho3_reg  <= rho3_next;
            ssq3_reg  <= ssq3_next;
            dsq3_reg  <= dsq3_next;
            rej3_reg  <= rej2_reg;
            body3_reg <= body2_reg;
        end
    end

    always_comb
    begin
        geo.valid  = v3_reg;
        geo.reject = rej3_reg;
        geo.body   = body3_reg;
        geo.rho2   = rho3_reg;
        geo.s2     = ssq3_reg;
        geo.d2     = dsq3_reg;
    end

endmodule

[src/rcpi_back.sv]
// ----------------------------------------------------------------------------
// rcpi_back
// Stages 4 and 5: split slope product, cap sphere sum, and the final
// decision select.
// ----------------------------------------------------------------------------
module rcpi_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pipe_en,
    input  rcpi_pkg::geo_t geo,
    input  rcpi_pkg::cfg_t cfg,
    output logic           res_valid,
    output logic           res_inside
);

    // stage 4
    logic                           v4_reg;
    logic                           rej4_reg, body4_reg;
    logic [rcpi_pkg::SmallSqW-1:0]  d2_4_reg;
    logic [rcpi_pkg::CapLhsW-1:0]   cap4_reg, cap4_next;
    logic [rcpi_pkg::PpLoW-1:0]     pplo4_reg, pplo4_next;
    logic [rcpi_pkg::PpHiW-1:0]     pphi4_reg, pphi4_next;

    // stage 5
    logic                           v5_reg;
    logic                           rej5_reg, body5_reg;
    logic [rcpi_pkg::LhsW-1:0]      lhs5_reg, lhs5_next;
    logic [rcpi_pkg::ProdW-1:0]     prod5_reg, prod5_next;
    logic                           capin5_reg, capin5_next;

    logic [rcpi_pkg::LoW-1:0]       rho_lo;
    logic [rcpi_pkg::HiW-1:0]       rho_hi;

    // rho2 * cot^2 as two partial products, summed one stage later
    always_comb
    begin
        rho_lo     = geo.rho2[rcpi_pkg::LoW-1:0];
        rho_hi     = geo.rho2[rcpi_pkg::RhoW-1:rcpi_pkg::LoW];
        pplo4_next = {{rcpi_pkg::LoW{1'b0}}, rho_lo}
                   * {{rcpi_pkg::LoW{1'b0}}, cfg.half_angle_cot_sq};
        pphi4_next = {{rcpi_pkg::CotW{1'b0}}, rho_hi}
                   * {{rcpi_pkg::HiW{1'b0}}, cfg.half_angle_cot_sq};
        cap4_next  = {5'b00000, geo.s2} + {1'b0, geo.rho2};
    end

    always_comb
    begin
        prod5_next  = {pphi4_reg, {rcpi_pkg::LoW{1'b0}}}
                    + {{(rcpi_pkg::ProdW - rcpi_pkg::PpLoW){1'b0}}, pplo4_reg};
        lhs5_next   = {d2_4_reg, 16'h0000};
        capin5_next = (cap4_reg <= {4'b0000, cfg.cap_radius_sq});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            v4_reg <= geo.valid;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            rej4_reg   <= geo.reject;
            body4_reg  <= geo.body;
            d2_4_reg   <= geo.d2;
            cap4_reg   <= cap4_next;
            pplo4_reg  <= pplo4_next;
            pphi4_reg  <= pphi4_next;
            rej5_reg   <= rej4_reg;
            body5_reg  <= body4_reg;
            lhs5_reg   <= lhs5_next;
            prod5_reg  <= prod5_next;
            capin5_reg <= capin5_next;
        end
    end

    always_comb
    begin
        res_valid = v5_reg;
        if (rej5_reg)
            res_inside = 1'b0;
        else if (body5_reg)
            res_inside = ({{(rcpi_pkg::ProdW - rcpi_pkg::LhsW){1'b0}}, lhs5_reg} >= prod5_reg);
        else
            res_inside = capin5_reg;
    end

endmodule

[src/rounded_cone_point_inclusion.sv]
// ----------------------------------------------------------------------------
// rounded_cone_point_inclusion
// out_valid comes from the output register that follows the five pipeline
// stages. Throughput: one point per cycle while in_stall is low.
// The 98-bit slope product is split over two stages, which sets the depth.
// A skid register behind the pipeline keeps in_stall a registered signal.
// Reset: valid bits cleared, geometry registers return to a unit-height cone.
// ----------------------------------------------------------------------------
module rounded_cone_point_inclusion (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rcpi_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [rcpi_pkg::CfgDataW-1:0]       cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [rcpi_pkg::CoordW-1:0]  point_x,
    input  logic signed [rcpi_pkg::CoordW-1:0]  point_y,
    input  logic signed [rcpi_pkg::CoordW-1:0]  point_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                inside_res
);

    rcpi_pkg::cfg_t cfg_reg;
    rcpi_pkg::geo_t geo;

    logic pipe_en, take;
    logic res_valid, res_inside;
    logic out_valid_reg, out_valid_next;
    logic out_inside_reg, out_inside_next;
    logic skid_valid_reg, skid_valid_next;
    logic skid_inside_reg, skid_inside_next;
    logic out_free, pipe_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tip_x             <= '0;
            cfg_reg.tip_y             <= '0;
            cfg_reg.tip_z             <= '0;
            cfg_reg.cone_height       <= rcpi_pkg::ConeHeightRst;
            cfg_reg.cap_flat_depth    <= '0;
            cfg_reg.cap_center_depth  <= '0;
            cfg_reg.cap_radius_sq     <= '0;
            cfg_reg.half_angle_cot_sq <= rcpi_pkg::CotSqRst;
        end
        else if (cfg_we)
        begin
            unique case (rcpi_pkg::cfg_reg_t'(cfg_index))
                rcpi_pkg::REG_TIP_X:       cfg_reg.tip_x <= cfg_data[rcpi_pkg::CoordW-1:0];
                rcpi_pkg::REG_TIP_Y:       cfg_reg.tip_y <= cfg_data[rcpi_pkg::CoordW-1:0];
                rcpi_pkg::REG_TIP_Z:       cfg_reg.tip_z <= cfg_data[rcpi_pkg::CoordW-1:0];
                rcpi_pkg::REG_CONE_HEIGHT:
                    cfg_reg.cone_height <= cfg_data[rcpi_pkg::DepthW-1:0];
                rcpi_pkg::REG_CAP_FLAT:
                    cfg_reg.cap_flat_depth <= cfg_data[rcpi_pkg::DepthW-1:0];
                rcpi_pkg::REG_CAP_CENTER:
                    cfg_reg.cap_center_depth <= cfg_data[rcpi_pkg::DepthW-1:0];
                rcpi_pkg::REG_CAP_RAD_SQ:
                    cfg_reg.cap_radius_sq <= cfg_data[rcpi_pkg::RadW-1:0];
                rcpi_pkg::REG_COT_SQ:
                    cfg_reg.half_angle_cot_sq <= cfg_data[rcpi_pkg::CotW-1:0];
                default: ;
            endcase
        end
    end

    // pipeline freezes only while the skid register holds a transaction
    assign pipe_en  = !skid_valid_reg;
    assign in_stall = skid_valid_reg;
    assign take     = in_valid && !skid_valid_reg;

    rcpi_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .pipe_en (pipe_en),
        .take    (take),
        .point_x (point_x),
        .point_y (point_y),
        .point_z (point_z),
        .cfg     (cfg_reg),
        .geo     (geo)
    );

    rcpi_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pipe_en    (pipe_en),
        .geo        (geo),
        .cfg        (cfg_reg),
        .res_valid  (res_valid),
        .res_inside (res_inside)
    );

    always_comb
    begin
        out_free         = !out_valid_reg || !out_stall;
        pipe_out         = res_valid && pipe_en;
        out_valid_next   = out_valid_reg;
        out_inside_next  = out_inside_reg;
        skid_valid_next  = skid_valid_reg;
        skid_inside_next = skid_inside_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_inside_next = skid_inside_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next  = pipe_out;
                out_inside_next = res_inside;
            end
        end
        else if (pipe_out)
        begin
            skid_valid_next  = 1'b1;
            skid_inside_next = res_inside;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_inside_reg  <= out_inside_next;
        skid_inside_reg <= skid_inside_next;
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = out_inside_reg;

endmodule

[dv/rounded_cone_point_inclusion_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rounded_cone_point_inclusion_tb
// Sends query points to the rounded cone inclusion block and compares every
// inside flag with an exact wide-integer prediction made when the point is
// accepted. Directed points sit on the tip, the cap sphere, the slope and the
// base plane, with reset, zero-slope, extreme and inconsistent geometry.
// Random traffic follows with cones of random shape and position and random
// idling on both channels.
// ----------------------------------------------------------------------------
module rounded_cone_point_inclusion_tb;

    localparam int ClkPeriod          = 8;
    localparam int ResetCycles        = 6;
    localparam int CycleLimit         = 100000;
    localparam int SettleCycles       = 12;
    localparam int RandomPerGeometry  = 78;
    localparam longint Unit           = 65536;   // 1.0 in Q16.16

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_we = 1'b0;
    logic [rcpi_pkg::CfgIdxW-1:0]       cfg_index = '0;
    logic [rcpi_pkg::CfgDataW-1:0]      cfg_data = '0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic signed [rcpi_pkg::CoordW-1:0] point_x = '0;
    logic signed [rcpi_pkg::CoordW-1:0] point_y = '0;
    logic signed [rcpi_pkg::CoordW-1:0] point_z = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic                               inside_res;

    rcpi_pkg::cfg_t geom;           // register contents as the block holds them
    bit   inside_expected[$];
    int   error_count = 0;
    int   cycle_count = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;

    // shape of the current random cone, in units
    real  shape_height;
    real  shape_cap;
    real  shape_flat;
    bit   shape_exact;

    rounded_cone_point_inclusion DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .inside_res (inside_res)
    );

    initial
    begin
        forever #(ClkPeriod / 2) clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CycleLimit)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("rounded_cone_point_inclusion_tb NOT OK");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic report_mismatch(string msg);
        error_count++;
        $display("%0t: mismatch: %s", $time, msg);
    endtask

    // outputs only move at the rising edge, so the falling edge sees what
    // the next rising edge will take
    always @(negedge clk)
    begin
        bit want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (inside_expected.size() == 0)
                report_mismatch("result with no point outstanding");
            else
            begin
                want = inside_expected.pop_front();
                if (inside_res !== want)
                    report_mismatch($sformatf("inside_res %b, expected %b",
                                              inside_res, want));
            end
        end
    end

    // exact inclusion test at 128 bits
    function automatic bit predict_inside(logic signed [rcpi_pkg::CoordW-1:0] px,
                                          logic signed [rcpi_pkg::CoordW-1:0] py,
                                          logic signed [rcpi_pkg::CoordW-1:0] pz);
        longint       dx, dy, dz, sh;
        longint       height, flat, center;
        logic [127:0] ax, az, ad, rho2, lhs, rhs, cot, rad;
        dx = longint'(px) - longint'($signed(geom.tip_x));
        dy = longint'(py) - longint'($signed(geom.tip_y));
        dz = longint'(pz) - longint'($signed(geom.tip_z));
        height = longint'(geom.cone_height);
        flat = longint'(geom.cap_flat_depth);
        center = longint'(geom.cap_center_depth);
        cot = {96'd0, geom.half_angle_cot_sq};
        rad = {65'd0, geom.cap_radius_sq};
        ax = 128'((dx < 0) ? -dx : dx);
        az = 128'((dz < 0) ? -dz : dz);
        rho2 = ax * ax + az * az;
        if (dy > 0 || dy < -height)
            return 1'b0;
        if (dy <= -flat)
        begin
            ad = 128'(-dy);
            lhs = (ad * ad) << 16;
            rhs = rho2 * cot;
            return lhs >= rhs;
        end
        sh = dy + center;
        ad = 128'((sh < 0) ? -sh : sh);
        lhs = ad * ad + rho2;
        return lhs <= rad;
    endfunction

    // coordinates wrap to the 32-bit port width
    task automatic send_point(longint x, longint y, longint z);
        bit stalled;
        logic signed [rcpi_pkg::CoordW-1:0] px, py, pz;
        px = rcpi_pkg::CoordW'(x);
        py = rcpi_pkg::CoordW'(y);
        pz = rcpi_pkg::CoordW'(z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        point_x <= px;
        point_y <= py;
        point_z <= pz;
        do
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end
        while (stalled);
        inside_expected.push_back(predict_inside(px, py, pz));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (inside_expected.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic load_geometry(rcpi_pkg::cfg_t g);
        rcpi_pkg::cfg_reg_t r;
        wait_idle();
        for (int i = 0; i < 8; i++)
        begin
            r = rcpi_pkg::cfg_reg_t'(i);
            cfg_we <= 1'b1;
            cfg_index <= r;
            case (r)
                rcpi_pkg::REG_TIP_X:       cfg_data <= {31'd0, g.tip_x};
                rcpi_pkg::REG_TIP_Y:       cfg_data <= {31'd0, g.tip_y};
                rcpi_pkg::REG_TIP_Z:       cfg_data <= {31'd0, g.tip_z};
                rcpi_pkg::REG_CONE_HEIGHT: cfg_data <= {32'd0, g.cone_height};
                rcpi_pkg::REG_CAP_FLAT:    cfg_data <= {32'd0, g.cap_flat_depth};
                rcpi_pkg::REG_CAP_CENTER:  cfg_data <= {32'd0, g.cap_center_depth};
                rcpi_pkg::REG_CAP_RAD_SQ:  cfg_data <= g.cap_radius_sq;
                rcpi_pkg::REG_COT_SQ:      cfg_data <= {31'd0, g.half_angle_cot_sq};
                default:                   cfg_data <= '0;
            endcase
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        geom = g;
    endtask

    function automatic real urand_real();
        return $urandom_range(0, 1000000) / 1000000.0;
    endfunction

    function automatic longint to_fix(real v);
        return longint'(v * 65536.0);
    endfunction

    // unit cone with a sharp tip at the origin, as left by reset
    task automatic test_reset_geometry();
        send_point(0, 0, 0);
        send_point(0, 1, 0);                             // one step above the tip
        send_point(0, -Unit, 0);
        send_point(0, -Unit - 1, 0);                     // just under the base
        send_point(Unit, -Unit, 0);                      // exactly on the slope
        send_point(Unit + 1, -Unit, 0);
        send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_point(32'h80000000, -Unit / 2, 32'h80000000);
    endtask

    // cap of radius 5, with the slope test taking over at depth 2
    task automatic test_rounded_cap();
        rcpi_pkg::cfg_t g;
        g.tip_x = rcpi_pkg::CoordW'(3 * Unit);
        g.tip_y = rcpi_pkg::CoordW'(-2 * Unit);
        g.tip_z = rcpi_pkg::CoordW'(Unit);
        g.cone_height = rcpi_pkg::DepthW'(20 * Unit);
        g.cap_flat_depth = rcpi_pkg::DepthW'(2 * Unit);
        g.cap_center_depth = rcpi_pkg::DepthW'(5 * Unit);
        g.cap_radius_sq = rcpi_pkg::RadW'((5 * Unit) * (5 * Unit));
        g.half_angle_cot_sq = rcpi_pkg::CotW'(Unit);
        load_geometry(g);
        send_point(g.tip_x, g.tip_y, g.tip_z);           // top of the sphere
        send_point(g.tip_x + 1, g.tip_y, g.tip_z);
        send_point(g.tip_x + 3 * Unit, g.tip_y - Unit, g.tip_z);  // on the sphere
        send_point(g.tip_x + 3 * Unit + 1, g.tip_y - Unit, g.tip_z);
        send_point(g.tip_x - 2 * Unit, g.tip_y - 2 * Unit, g.tip_z);
    endtask

    task automatic test_zero_cotangent();
        rcpi_pkg::cfg_t g;
        g = '0;
        g.cone_height = rcpi_pkg::DepthW'(4 * Unit);
        load_geometry(g);
        send_point(32'h7fffffff, -2 * Unit, 32'h80000000);
        send_point(0, 1, 0);
        send_point(0, -4 * Unit - 1, 0);
    endtask

    task automatic test_extreme_registers();
        rcpi_pkg::cfg_t g;
        g.tip_x = 32'h80000000;
        g.tip_y = 32'h7fffffff;
        g.tip_z = 32'h80000000;
        g.cone_height = '1;
        g.cap_flat_depth = '0;
        g.cap_center_depth = '1;
        g.cap_radius_sq = '1;
        g.half_angle_cot_sq = '1;
        load_geometry(g);
        send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_point(32'h7fffffff, 0, 32'h7fffffff);
        send_point(32'h80000000, 32'h7fffffff, 32'h80000000);
        send_point(32'h80000000, 0, 32'h80000000);
        // cap reaches all the way down to the base
        g.cap_flat_depth = '1;
        g.half_angle_cot_sq = '0;
        load_geometry(g);
        send_point(32'h7fffffff, 0, 32'h7fffffff);
        send_point(32'h80000000, 1, 32'h80000000);
        send_point(32'h7fffffff, 1, 32'h7fffffff);
    endtask

    // cap region deeper than the cone itself
    task automatic test_inconsistent_geometry();
        rcpi_pkg::cfg_t g;
        g = '0;
        g.cone_height = rcpi_pkg::DepthW'(3 * Unit);
        g.cap_flat_depth = rcpi_pkg::DepthW'(5 * Unit);
        g.cap_radius_sq = rcpi_pkg::RadW'((2 * Unit) * (2 * Unit));
        g.half_angle_cot_sq = rcpi_pkg::CotW'(Unit);
        load_geometry(g);
        send_point(0, -2 * Unit, 0);
        send_point(0, -3 * Unit, 0);
        send_point(Unit, -Unit, 0);
    endtask

    task automatic randomize_geometry();
        rcpi_pkg::cfg_t g;
        real    angle;
        longint r_fix;
        shape_exact = ($urandom_range(3) == 0);
        angle = shape_exact ? 0.7853981634 : 0.17 + 1.05 * urand_real();
        shape_height = 1.0 + 199.0 * urand_real();
        shape_cap = ($urandom_range(4) == 0) ? 0.0 : 4.0 * urand_real();
        shape_flat = shape_cap * (1.0 - $sin(angle));
        g.tip_x = rcpi_pkg::CoordW'(to_fix(2000.0 * urand_real() - 1000.0));
        g.tip_y = rcpi_pkg::CoordW'(to_fix(2000.0 * urand_real() - 1000.0));
        g.tip_z = rcpi_pkg::CoordW'(to_fix(2000.0 * urand_real() - 1000.0));
        g.cone_height = rcpi_pkg::DepthW'(to_fix(shape_height));
        g.cap_flat_depth = rcpi_pkg::DepthW'(to_fix(shape_flat));
        r_fix = to_fix(shape_cap);
        g.cap_center_depth = rcpi_pkg::DepthW'(r_fix);
        g.cap_radius_sq = rcpi_pkg::RadW'(r_fix * r_fix);
        if (shape_exact)
            g.half_angle_cot_sq = rcpi_pkg::CotW'(Unit);
        else
            g.half_angle_cot_sq =
                rcpi_pkg::CotW'(to_fix(1.0 / ($tan(angle) * $tan(angle))));
        load_geometry(g);
    endtask

    task automatic send_random_point();
        int     pick;
        real    dy, depth, rb, rho, f, cotr, t;
        longint ox, oy, oz;
        pick = $urandom_range(99);
        if (pick < 12)
            send_point($urandom, $urandom, $urandom);
        else if (pick < 20)
            send_point(geom.tip_x + int'($urandom_range(8)) - 4,
                       geom.tip_y + int'($urandom_range(8)) - 4,
                       geom.tip_z + int'($urandom_range(8)) - 4);
        else
        begin
            dy = -shape_height * (1.1 * urand_real() - 0.05);
            oy = to_fix(dy);
            if (shape_exact && $urandom_range(3) == 0)
            begin
                // on the slope exactly when the cotangent is one
                ox = $urandom_range(1) ? oy : -oy;
                oz = 0;
            end
            else
            begin
                depth = -dy;
                cotr = real'(geom.half_angle_cot_sq) / 65536.0;
                if (depth >= shape_flat)
                    rb = depth / $sqrt(cotr);
                else
                begin
                    t = shape_cap * shape_cap - (dy + shape_cap) * (dy + shape_cap);
                    rb = (t > 0.0) ? $sqrt(t) : 0.0;
                end
                rho = rb * (0.85 + 0.3 * urand_real());
                f = 2.0 * urand_real() - 1.0;
                ox = to_fix(rho * f);
                oz = to_fix(rho * $sqrt(1.0 - f * f));
                if ($urandom_range(1))
                    oz = -oz;
            end
            send_point(geom.tip_x + ox, geom.tip_y + oy, geom.tip_z + oz);
        end
    endtask

    task automatic test_random_traffic(int sender_pct, int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        repeat (3)
        begin
            randomize_geometry();
            repeat (RandomPerGeometry) send_random_point();
        end
    endtask

    initial
    begin
        geom = '{tip_x: '0, tip_y: '0, tip_z: '0,
                 cone_height: rcpi_pkg::ConeHeightRst,
                 cap_flat_depth: '0, cap_center_depth: '0, cap_radius_sq: '0,
                 half_angle_cot_sq: rcpi_pkg::CotSqRst};
        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_geometry();
        test_rounded_cap();
        test_zero_cotangent();
        test_extreme_registers();
        test_inconsistent_geometry();
        test_random_traffic(24, 73);
        test_random_traffic(73, 24);
        test_random_traffic(0, 0);
        wait_idle();

        if (error_count == 0)
            $display("rounded_cone_point_inclusion_tb OK");
        else
            $display("rounded_cone_point_inclusion_tb NOT OK");
        $finish;
    end

endmodule
